// ===== rtl/pvg_pkg.sv =====
// ============================================================================
// pvg_pkg: shared types and constants for the pose variance gate
// coordinate type, register defaults and the control bundle of the
// squared-difference accumulator
// ============================================================================
package pvg_pkg;

    localparam int COORD_W        = 32;
    localparam int LIMIT_W        = 32;
    localparam int FRAC_W         = 16;
    localparam int WINDOW_DEFAULT = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd3277;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LIMIT_W-1:0]        limit_t;

    // control from the sequencer to the accumulator
    typedef struct packed {
        logic clear;
        logic issue;
    } sq_ctrl_t;

endpackage

// ===== rtl/pvg_pose_if.sv =====
// ============================================================================
// pvg_pose_if: pose input channel
// valid/ready channel carrying one pose beat (x, y, heading)
// ============================================================================
interface pvg_pose_if;
    import pvg_pkg::*;

    logic   valid;
    logic   ready;
    coord_t x_pos;
    coord_t y_pos;
    coord_t heading;

    modport source (output valid, output x_pos, output y_pos, output heading, input ready);
    modport sink   (input valid, input x_pos, input y_pos, input heading, output ready);

endinterface

// ===== rtl/pvg_result_if.sv =====
// ============================================================================
// pvg_result_if: gated pose output channel
// valid/ready channel carrying one filtered pose beat and the gated flag
// ============================================================================
interface pvg_result_if;
    import pvg_pkg::*;

    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_heading;
    logic   gated;

    modport source (output valid, output out_x, output out_y, output out_heading,
                    output gated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_heading,
                    input gated, output ready);

endinterface

// ===== rtl/pvg_sq_acc.sv =====
// ============================================================================
// pvg_sq_acc: shared squared-difference accumulator
// forms |pivot - operand|, squares it on one 32x32 multiplier and adds the
// square into a wide accumulator; two pipeline stages ahead of the add
// ============================================================================
module pvg_sq_acc #(
    parameter int ACC_W = 71
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pvg_pkg::sq_ctrl_t   ctrl,
    input  pvg_pkg::coord_t     pivot,
    input  pvg_pkg::coord_t     operand,
    output logic [ACC_W-1:0]    acc,
    output logic                busy
);
    import pvg_pkg::*;

    logic signed [COORD_W:0]  diff;
    logic [COORD_W-1:0]       mag;
    logic [2*COORD_W-1:0]     sq;

    logic [COORD_W-1:0]       mag_reg;
    logic [2*COORD_W-1:0]     prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     v1_reg;
    logic                     v2_reg;

    assign diff = $signed({pivot[COORD_W-1], pivot}) - $signed({operand[COORD_W-1], operand});
    assign mag  = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
    assign sq   = {{COORD_W{1'b0}}, mag_reg} * {{COORD_W{1'b0}}, mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag;
        prod_reg <= sq;
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;

endmodule

// ===== rtl/pose_variance_gate_top.sv =====
// ============================================================================
// pose_variance_gate_top: sliding-window variance outlier gate for 2-D poses
// keeps the last WINDOW x/y samples and gates a pose to zero when the sample
// variance of x or y reaches variance_limit
// ----------------------------------------------------------------------------
//   channel     dir   beat contents
//   pose_in     in    x_pos, y_pos, heading (signed Q16.16)
//   result_out  out   out_x, out_y, out_heading, gated
//   cfg_wr_*    in    variance_limit (unsigned Q16.16)
//
// with n stored samples the time from accept to result is set by the pair loop
// that runs every pair of samples, x then y, through one shared square-and-add
// unit. a pose with x and y both zero skips the window and the pair loop, and
// one with n < 2 skips the pair loop.
// reset empties the window and loads the default limit; no input beat is
// taken while an item is in work, and a finished result waits in the output
// register while the next beat is accepted.
// ============================================================================
module pose_variance_gate_top #(
    parameter int WINDOW = pvg_pkg::WINDOW_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    pvg_pose_if.sink            pose_in,
    pvg_result_if.source        result_out,
    input  logic                cfg_wr_en,
    input  pvg_pkg::limit_t     cfg_wr_data
);
    import pvg_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int PAIRS   = WINDOW * (WINDOW - 1) / 2;
    localparam int ACC_W   = 2 * COORD_W + $clog2(PAIRS + 1);
    localparam int TPROD_W = LIMIT_W + 2 * CNT_W;
    localparam int THR_W   = TPROD_W + FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_LOAD,
        S_PAIR,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t              state_reg;
    limit_t              limit_reg;
    coord_t              win_x_reg [WINDOW];
    coord_t              win_y_reg [WINDOW];
    logic [CNT_W-1:0]    fill_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    j_reg;
    logic                coord_sel_reg;
    coord_t              pivot_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                gate_reg;
    logic                zero_in_reg;
    coord_t              x_hold_reg;
    coord_t              y_hold_reg;
    coord_t              h_hold_reg;
    logic                out_valid_reg;
    coord_t              out_x_reg;
    coord_t              out_y_reg;
    coord_t              out_h_reg;
    logic                out_gated_reg;

    logic                in_beat;
    logic                in_zero;
    logic [IDX_W-1:0]    rd_idx;
    coord_t              operand;
    logic [2*CNT_W-1:0]  nn1;
    logic [TPROD_W-1:0]  thr_prod;
    logic [IDX_W-1:0]    last_j;
    logic [IDX_W-1:0]    last_i;
    logic                over;
    logic                drop;
    sq_ctrl_t            sq_ctrl;
    logic [ACC_W-1:0]    acc;
    logic                acc_busy;

    assign in_beat = pose_in.valid & pose_in.ready;
    assign in_zero = (pose_in.x_pos == '0) && (pose_in.y_pos == '0);

    assign rd_idx  = (state_reg == S_LOAD) ? i_reg : j_reg;
    assign operand = coord_sel_reg ? win_y_reg[rd_idx] : win_x_reg[rd_idx];

    assign nn1      = {{CNT_W{1'b0}}, fill_reg} * {{CNT_W{1'b0}}, fill_reg - 1'b1};
    assign thr_prod = TPROD_W'(limit_reg) * TPROD_W'(nn1);

    assign last_j = IDX_W'(fill_reg - 1'b1);
    assign last_i = IDX_W'(fill_reg - 2'd2);
    assign over   = acc >= ACC_W'(thr_reg);
    assign drop   = gate_reg | zero_in_reg;

    assign sq_ctrl.issue = (state_reg == S_PAIR);
    assign sq_ctrl.clear = (state_reg == S_THR) ||
                           ((state_reg == S_DRAIN) && !acc_busy && !coord_sel_reg);

    pvg_sq_acc #(
        .ACC_W (ACC_W)
    ) u_sq_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sq_ctrl),
        .pivot   (pivot_reg),
        .operand (operand),
        .acc     (acc),
        .busy    (acc_busy)
    );

    // sample window, written only with nonzero poses
    always_ff @(posedge clk)
    begin
        if (in_beat && !in_zero)
        begin
            win_x_reg[slot_reg] <= pose_in.x_pos;
            win_y_reg[slot_reg] <= pose_in.y_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            fill_reg      <= '0;
            slot_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            coord_sel_reg <= 1'b0;
            gate_reg      <= 1'b0;
            zero_in_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end

            if (out_valid_reg && result_out.ready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        x_hold_reg    <= pose_in.x_pos;
                        y_hold_reg    <= pose_in.y_pos;
                        h_hold_reg    <= pose_in.heading;
                        zero_in_reg   <= in_zero;
                        gate_reg      <= 1'b0;
                        coord_sel_reg <= 1'b0;
                        if (in_zero)
                        begin
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            slot_reg  <= (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                            if (fill_reg != CNT_W'(WINDOW))
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            state_reg <= S_THR;
                        end
                    end
                end

                S_THR:
                begin
                    thr_reg <= {thr_prod, {FRAC_W{1'b0}}};
                    i_reg   <= '0;
                    j_reg   <= IDX_W'(1);
                    if (fill_reg < CNT_W'(2))
                    begin
                        gate_reg  <= (limit_reg == '0);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end

                S_LOAD:
                begin
                    pivot_reg <= operand;
                    state_reg <= S_PAIR;
                end

                S_PAIR:
                begin
                    if (j_reg == last_j)
                    begin
                        if (i_reg == last_i)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            j_reg     <= i_reg + 2'd2;
                            state_reg <= S_LOAD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end

                S_DRAIN:
                begin
                    if (!acc_busy)
                    begin
                        gate_reg <= gate_reg | over;
                        if (!coord_sel_reg)
                        begin
                            coord_sel_reg <= 1'b1;
                            i_reg         <= '0;
                            j_reg         <= IDX_W'(1);
                            state_reg     <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end

                S_RESULT:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= drop ? '0 : x_hold_reg;
                        out_y_reg     <= drop ? '0 : y_hold_reg;
                        out_h_reg     <= drop ? '0 : h_hold_reg;
                        out_gated_reg <= gate_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pose_in.ready          = (state_reg == S_IDLE);
    assign result_out.valid       = out_valid_reg;
    assign result_out.out_x       = out_x_reg;
    assign result_out.out_y       = out_y_reg;
    assign result_out.out_heading = out_h_reg;
    assign result_out.gated       = out_gated_reg;

endmodule

// ===== test/pose_variance_gate_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pose_variance_gate_top_tb: self-checking bench for the pose variance gate
// directed poses (zero pose, short window, field extremes, zero and full-scale
// limits) followed by random pose clusters with outliers across several limit
// settings; every result beat is checked against an in-bench window model (fixed
// wants for marked directed poses) under random sender bursts and receiver stalls
// ============================================================================
module pose_variance_gate_top_tb;
    import pvg_pkg::*;

    localparam int WIN         = WINDOW_DEFAULT;
    localparam int PHASES      = 7;
    localparam int PHASE_POSES = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 40;
    localparam int PRINT_CAP   = 100;
    localparam int NSTEP       = 24;

    localparam coord_t ONE   = 32'sh0001_0000;
    localparam coord_t TWO   = 32'sh0002_0000;
    localparam coord_t THREE = 32'sh0003_0000;
    localparam coord_t MAXC  = 32'sh7FFF_FFFF;
    localparam coord_t MINC  = 32'sh8000_0000;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t h;
        logic   gated;
    } pose_res_t;

    typedef struct packed {
        bit        cfg;
        limit_t    lim;
        coord_t    x;
        coord_t    y;
        coord_t    h;
        bit        chk;
        pose_res_t want;
    } step_t;

    localparam pose_res_t NO_POSE    = '0;
    localparam pose_res_t GATED_POSE = '{32'sd0, 32'sd0, 32'sd0, 1'b1};

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    limit_t cfg_wr_data = '0;

    pvg_pose_if   pose_ch ();
    pvg_result_if res_ch ();

    pose_variance_gate_top #(.WINDOW(WIN)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pose_in     (pose_ch),
        .result_out  (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // window model
    coord_t x_hist [WIN] = '{default: '0};
    coord_t y_hist [WIN] = '{default: '0};
    int     stored       = 0;
    int     slot         = 0;
    limit_t limit_q      = LIMIT_RESET;

    pose_res_t due_poses [$];
    pose_res_t row_want    = NO_POSE;
    bit        row_checked = 1'b0;
    int        mismatches  = 0;
    int        quiet_cycles = 0;
    int        res_beats   = 0;

    coord_t center_x  = ONE;
    coord_t center_y  = TWO;
    int     spread_sh = 8;

    step_t plan [NSTEP] = '{
        '{1'b0, '0, 32'sd0, 32'sd0, MAXC, 1'b1, NO_POSE},
        '{1'b1, '0, 32'sd0, 32'sd0, 32'sd0, 1'b0, NO_POSE},
        '{1'b0, '0, ONE, TWO, 32'sh4000_0000, 1'b1, GATED_POSE},
        '{1'b1, LIMIT_RESET, 32'sd0, 32'sd0, 32'sd0, 1'b0, NO_POSE},
        '{1'b0, '0, ONE, TWO, MINC, 1'b1, '{ONE, TWO, MINC, 1'b0}},
        '{1'b0, '0, MAXC, MINC, 32'sh1234_5678, 1'b1, GATED_POSE},
        '{1'b0, '0, MINC, MAXC, -32'sd1, 1'b1, GATED_POSE},
        '{1'b0, '0, 32'sd0, 32'sd0, -32'sd1, 1'b1, NO_POSE},
        '{1'b0, '0, 32'sd0, THREE, 32'sd1, 1'b0, NO_POSE},
        '{1'b0, '0, ONE + 32'sd5, 32'sd0, 32'sd2, 1'b0, NO_POSE},
        '{1'b0, '0, ONE + 32'sd3, TWO - 32'sd2, 32'sd3, 1'b0, NO_POSE},
        '{1'b0, '0, ONE - 32'sd4, TWO + 32'sd7, 32'sd4, 1'b0, NO_POSE},
        '{1'b0, '0, ONE + 32'sd1, TWO + 32'sd1, 32'sd5, 1'b0, NO_POSE},
        '{1'b0, '0, ONE, TWO - 32'sd5, 32'sd6, 1'b0, NO_POSE},
        '{1'b0, '0, ONE + 32'sd2, TWO, 32'sd7, 1'b0, NO_POSE},
        '{1'b1, '1, 32'sd0, 32'sd0, 32'sd0, 1'b0, NO_POSE},
        '{1'b0, '0, MAXC, MAXC, 32'sd8, 1'b0, NO_POSE},
        '{1'b0, '0, MINC, MINC, 32'sd9, 1'b1, GATED_POSE},
        '{1'b1, 32'h0001_0000, 32'sd0, 32'sd0, 32'sd0, 1'b0, NO_POSE},
        '{1'b0, '0, 32'sh0005_0000, 32'sh0005_0000, 32'sd10, 1'b0, NO_POSE},
        '{1'b0, '0, 32'sh0005_8000, 32'sh0004_8000, 32'sd11, 1'b0, NO_POSE},
        '{1'b0, '0, 32'sh0004_8000, 32'sh0005_8000, 32'sd12, 1'b0, NO_POSE},
        '{1'b0, '0, 32'sh0007_0000, 32'sh0003_0000, 32'sd13, 1'b0, NO_POSE},
        '{1'b0, '0, 32'sh0005_0000, -32'sh0005_0000, 32'sd14, 1'b0, NO_POSE}
    };

    // sum of squared pair differences against limit * n * (n - 1)
    function automatic bit spread_reached(coord_t smp [WIN], int n);
        logic [127:0] acc;
        logic [127:0] thr;
        longint       d;
        logic [63:0]  m;
        if (n < 2)
            return limit_q == '0;
        acc = '0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i + 1; j < n; j++)
            begin
                d = longint'(smp[i]) - longint'(smp[j]);
                m = (d < 0) ? -d : d;
                acc += {64'd0, m} * {64'd0, m};
            end
        end
        thr = ({96'd0, limit_q} << FRAC_W) * n * (n - 1);
        return acc >= thr;
    endfunction

    function automatic pose_res_t gate_pose(coord_t x, coord_t y, coord_t h);
        pose_res_t r;
        if (x == '0 && y == '0)
            return NO_POSE;
        x_hist[slot] = x;
        y_hist[slot] = y;
        slot = (slot + 1 == WIN) ? 0 : slot + 1;
        if (stored < WIN)
            stored++;
        if (spread_reached(x_hist, stored) || spread_reached(y_hist, stored))
            r = GATED_POSE;
        else
            r = '{x, y, h, 1'b0};
        return r;
    endfunction

    task automatic report_error(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic put_pose(coord_t x, coord_t y, coord_t h, bit chk, pose_res_t want);
        @(negedge clk);
        pose_ch.valid   <= 1'b1;
        pose_ch.x_pos   <= x;
        pose_ch.y_pos   <= y;
        pose_ch.heading <= h;
        row_checked = chk;
        row_want    = want;
        @(posedge clk);
        while (!pose_ch.ready)
            @(posedge clk);
    endtask

    task automatic idle_for(int n);
        repeat (n)
        begin
            @(negedge clk);
            pose_ch.valid   <= 1'b0;
            pose_ch.x_pos   <= coord_t'($urandom);
            pose_ch.y_pos   <= coord_t'($urandom);
            pose_ch.heading <= coord_t'($urandom);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        pose_ch.valid <= 1'b0;
        while (due_poses.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(limit_t v);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        limit_q = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // beat monitor and scoreboard
    always @(posedge clk)
    begin : beat_monitor
        pose_res_t want;
        pose_res_t got;
        bit        took_pose;
        bit        took_res;
        took_pose = rst_n && pose_ch.valid && pose_ch.ready;
        took_res  = rst_n && res_ch.valid && res_ch.ready;
        if (took_res)
        begin
            got = '{res_ch.out_x, res_ch.out_y, res_ch.out_heading, res_ch.gated};
            if (due_poses.size() == 0)
                report_error($sformatf("result %0d with no pose outstanding", res_beats));
            else
            begin
                want = due_poses.pop_front();
                if (got.x !== want.x)
                    report_error($sformatf("result %0d out_x %h, want %h",
                                           res_beats, got.x, want.x));
                if (got.y !== want.y)
                    report_error($sformatf("result %0d out_y %h, want %h",
                                           res_beats, got.y, want.y));
                if (got.h !== want.h)
                    report_error($sformatf("result %0d out_heading %h, want %h",
                                           res_beats, got.h, want.h));
                if (got.gated !== want.gated)
                    report_error($sformatf("result %0d gated %b, want %b",
                                           res_beats, got.gated, want.gated));
            end
            res_beats++;
        end
        if (took_pose)
        begin
            want = gate_pose(pose_ch.x_pos, pose_ch.y_pos, pose_ch.heading);
            if (row_checked)
                want = row_want;
            due_poses.push_back(want);
        end
        quiet_cycles = (took_pose || took_res) ? 0 : quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[%0t] no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // receiver stall pattern
    initial
    begin : result_stall
        int span;
        int mode;
        int tick;
        res_ch.ready = 1'b0;
        span = 0;
        mode = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(30, 300);
            end
            span--;
            tick++;
            case (mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 9) < 7);
                2:       res_ch.ready <= ($urandom_range(0, 9) < 2);
                default: res_ch.ready <= ((tick % 13) < 4);
            endcase
        end
    end

    initial
    begin : stimulus
        coord_t rx;
        coord_t ry;
        coord_t rh;
        int     left;
        int     burst;
        int     mode;
        bit     choppy;
        pose_ch.valid   = 1'b0;
        pose_ch.x_pos   = '0;
        pose_ch.y_pos   = '0;
        pose_ch.heading = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NSTEP; i++)
        begin
            if (plan[i].cfg)
                set_limit(plan[i].lim);
            else
            begin
                put_pose(plan[i].x, plan[i].y, plan[i].h, plan[i].chk, plan[i].want);
                idle_for($urandom_range(0, 2));
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_limit(LIMIT_RESET);
                1:       set_limit(limit_t'($urandom_range(1, 60000)));
                2:       set_limit('0);
                3:       set_limit('1);
                4:       set_limit(limit_t'($urandom));
                5:       set_limit(limit_t'($urandom >> $urandom_range(8, 28)));
                default: set_limit(limit_t'(1));
            endcase
            left = PHASE_POSES;
            while (left > 0)
            begin
                burst     = $urandom_range(1, 24);
                spread_sh = $urandom_range(1, 24);
                choppy    = $urandom_range(0, 1);
                if ($urandom_range(0, 9) == 0)
                begin
                    center_x = coord_t'($urandom) >>> $urandom_range(4, 16);
                    center_y = coord_t'($urandom) >>> $urandom_range(4, 16);
                end
                while (burst > 0 && left > 0)
                begin
                    mode = $urandom_range(0, 99);
                    rh   = coord_t'($urandom);
                    rx   = center_x + coord_t'(int'($urandom_range(0, (1 << spread_sh) - 1))
                                               - (1 << (spread_sh - 1)));
                    ry   = center_y + coord_t'(int'($urandom_range(0, (1 << spread_sh) - 1))
                                               - (1 << (spread_sh - 1)));
                    if (mode < 8)
                    begin
                        rx = '0;
                        ry = '0;
                    end
                    else if (mode < 12)
                        rx = '0;
                    else if (mode < 16)
                        ry = '0;
                    else if (mode < 24)
                    begin
                        rx = coord_t'($urandom);
                        ry = coord_t'($urandom);
                    end
                    else if (mode < 30)
                        rx = center_x + coord_t'($urandom_range(1 << 20, 1 << 30));
                    put_pose(rx, ry, rh, 1'b0, NO_POSE);
                    burst--;
                    left--;
                    if (choppy && $urandom_range(0, 3) == 0)
                        idle_for($urandom_range(1, 3));
                end
                if ($urandom_range(0, 15) == 0)
                    drain_results();
                else if ($urandom_range(0, 2) == 0)
                    idle_for($urandom_range(4, 40));
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (due_poses.size() != 0)
            report_error($sformatf("%0d results never arrived", due_poses.size()));
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
